[sv/mwtf_pkg.sv]
// ----------------------------------------------------------------------------
// mwtf_pkg
// Shared types and constants of the markup word tokenizer and filter.
// ----------------------------------------------------------------------------
package mwtf_pkg;

	typedef struct packed {
		logic [3:0] min_len;
		logic [3:0] max_len;
		logic [3:0] run_limit;
	} cfg_t;

	typedef enum logic [1:0] {
		REG_MIN_LEN   = 2'd0,
		REG_MAX_LEN   = 2'd1,
		REG_RUN_LIMIT = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OP_BYTE  = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	localparam logic [3:0] RST_MIN_LEN   = 4'd4;
	localparam logic [3:0] RST_MAX_LEN   = 4'd14;
	localparam logic [3:0] RST_RUN_LIMIT = 4'd4;

	localparam logic [7:0] CH_TAG_OPEN  = 8'h3C;
	localparam logic [7:0] CH_TAG_CLOSE = 8'h3E;
	localparam logic [7:0] CH_APOS      = 8'h27;
	localparam logic [7:0] CH_LOWER_S   = 8'h73;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

	localparam logic [6:0] LETTER_BASE = 7'd97;
	localparam logic [3:0] RUN_MAX     = 4'd15;

	function automatic logic is_vowel(logic [4:0] idx);
		return (idx == 5'd0) || (idx == 5'd4) || (idx == 5'd8) ||
			(idx == 5'd14) || (idx == 5'd20);
	endfunction

endpackage

[sv/markup_word_tokenizer_filter_core.sv]
// ----------------------------------------------------------------------------
// markup_word_tokenizer_filter_core
// Markup word tokenizer and filter: parses a byte stream, keeps filtered
// words and emits them letter by letter with a last marker.
// ----------------------------------------------------------------------------
// Input: one byte per cycle while the word queue has room (QUEUE_DEPTH words).
// Output: one letter per cycle while word_ready is high; first letter of a kept word
// passes the queue write, then the output register, after the closing item is taken.
// Emission rate: the letter emitter reads one head-word letter per cycle unless stalled.
// Reset is asynchronous: parse state, queue and output valid clear at once,
// registers return to 4 / 14 / 4; the letter buffer is never cleared.
module markup_word_tokenizer_filter_core #(
	parameter int WORD_BUFFER_DEPTH = 14,
	parameter int QUEUE_DEPTH       = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic        operation,
	input  logic [7:0]  text_byte,
	output logic        word_valid,
	input  logic        word_ready,
	output logic [6:0]  letter,
	output logic        last
);
	import mwtf_pkg::*;

	localparam int LW = $clog2(WORD_BUFFER_DEPTH + 2);
	localparam int QW = WORD_BUFFER_DEPTH * 5 + LW;

	cfg_t          cfg_q;
	reg_idx_t      reg_idx;
	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	logic [QW-1:0] push_data;
	logic [QW-1:0] head_data;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (reg_idx)
			REG_MIN_LEN:   prdata = {28'd0, cfg_q.min_len};
			REG_MAX_LEN:   prdata = {28'd0, cfg_q.max_len};
			REG_RUN_LIMIT: prdata = {28'd0, cfg_q.run_limit};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_len   <= RST_MIN_LEN;
			cfg_q.max_len   <= RST_MAX_LEN;
			cfg_q.run_limit <= RST_RUN_LIMIT;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_MIN_LEN:   cfg_q.min_len   <= pwdata[3:0];
				REG_MAX_LEN:   cfg_q.max_len   <= pwdata[3:0];
				REG_RUN_LIMIT: cfg_q.run_limit <= pwdata[3:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	mwtf_front #(
		.DEPTH (WORD_BUFFER_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.operation  (operation),
		.text_byte  (text_byte),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	mwtf_wordq #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_wordq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head_data (head_data),
		.empty     (q_empty)
	);

	mwtf_back #(
		.DEPTH (WORD_BUFFER_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_data  (head_data),
		.q_empty    (q_empty),
		.pop        (pop),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.letter     (letter),
		.last       (last)
	);

endmodule

[sv/mwtf_front.sv]
// ----------------------------------------------------------------------------
// mwtf_front
// Byte parser: tag skipping, apostrophe handling, word collection and the
// length, vowel and consonant-run filter. Kept words go to the word queue.
// ----------------------------------------------------------------------------
module mwtf_front #(
	parameter int DEPTH = 14,
	localparam int LW = $clog2(DEPTH + 2),
	localparam int QW = DEPTH * 5 + LW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mwtf_pkg::cfg_t     cfg,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic               operation,
	input  logic [7:0]         text_byte,
	input  logic               q_full,
	output logic               push,
	output logic [QW-1:0]      push_data
);
	import mwtf_pkg::*;

	localparam int IW = $clog2(DEPTH);

	logic           inside_tag_q;
	logic           apos_q;
	logic [LW-1:0]  len_q;
	logic           vowel_q;
	logic [3:0]     run_q;
	logic           viol_q;
	logic [4:0]     buf_q [DEPTH];

	logic           accept;
	logic           flush;
	logic           is_upper;
	logic           is_lower;
	logic           is_letter;
	logic           pass;
	logic           do_add;
	logic           do_close;
	logic           keep;
	logic [4:0]     idx;
	logic [3:0]     run_inc;

	assign byte_ready = !q_full;
	assign accept     = byte_valid && byte_ready;
	assign flush      = (operation == OP_FLUSH);
	assign is_upper   = (text_byte >= CH_UPPER_A) && (text_byte <= CH_UPPER_Z);
	assign is_lower   = (text_byte >= CH_LOWER_A) && (text_byte <= CH_LOWER_Z);
	assign is_letter  = is_upper || is_lower;
	assign idx        = is_upper ? 5'(text_byte - CH_UPPER_A) : 5'(text_byte - CH_LOWER_A);
	assign pass       = !flush && (text_byte != CH_TAG_OPEN) && (text_byte != CH_TAG_CLOSE) &&
		!inside_tag_q && !(apos_q && (text_byte == CH_LOWER_S));
	assign do_add     = accept && pass && is_letter;
	assign do_close   = accept && (flush || (pass && !is_letter));
	assign run_inc    = (run_q == RUN_MAX) ? run_q : run_q + 4'd1;

	assign keep = (len_q != '0) && (len_q <= LW'(DEPTH)) &&
		(8'(len_q) >= 8'(cfg.min_len)) && (8'(len_q) <= 8'(cfg.max_len)) &&
		vowel_q && !viol_q;
	assign push = do_close && keep;

	always_comb begin
		push_data = '0;
		for (int k = 0; k < DEPTH; k++) begin
			push_data[k*5 +: 5] = buf_q[k];
		end
		push_data[QW-1 -: LW] = len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_tag_q <= 1'b0;
			apos_q       <= 1'b0;
			len_q        <= '0;
			vowel_q      <= 1'b0;
			run_q        <= '0;
			viol_q       <= 1'b0;
		end else if (accept) begin
			if (flush) begin
				inside_tag_q <= 1'b0;
				apos_q       <= 1'b0;
			end else if (text_byte == CH_TAG_OPEN) begin
				inside_tag_q <= 1'b1;
			end else if (text_byte == CH_TAG_CLOSE) begin
				inside_tag_q <= 1'b0;
			end else if (!inside_tag_q) begin
				if (apos_q && (text_byte == CH_LOWER_S)) begin
					apos_q <= 1'b0;
				end else begin
					apos_q <= (text_byte == CH_APOS);
				end
			end
			if (do_close) begin
				len_q   <= '0;
				vowel_q <= 1'b0;
				run_q   <= '0;
				viol_q  <= 1'b0;
			end else if (do_add) begin
				if (len_q <= LW'(DEPTH)) begin
					len_q <= len_q + LW'(1);
				end
				if (is_vowel(idx)) begin
					vowel_q <= 1'b1;
					run_q   <= '0;
				end else begin
					run_q <= run_inc;
					if (run_inc >= cfg.run_limit) begin
						viol_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_add && (len_q < LW'(DEPTH))) begin
			buf_q[len_q[IW-1:0]] <= idx;
		end
	end

endmodule

[sv/mwtf_wordq.sv]
// ----------------------------------------------------------------------------
// mwtf_wordq
// Small queue of kept words between the parser and the letter emitter.
// ----------------------------------------------------------------------------
module mwtf_wordq #(
	parameter int WIDTH = 74,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[sv/mwtf_back.sv]
// ----------------------------------------------------------------------------
// mwtf_back
// Letter emitter: walks the head word of the queue one letter per cycle
// into the output register, unless word_ready stalls it, and marks the final letter.
// ----------------------------------------------------------------------------
module mwtf_back #(
	parameter int DEPTH = 14,
	localparam int LW = $clog2(DEPTH + 2),
	localparam int QW = DEPTH * 5 + LW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [QW-1:0] head_data,
	input  logic          q_empty,
	output logic          pop,
	output logic          word_valid,
	input  logic          word_ready,
	output logic [6:0]    letter,
	output logic          last
);
	import mwtf_pkg::*;

	localparam int IW = $clog2(DEPTH);

	logic [4:0]    letters [DEPTH];
	logic [LW-1:0] len;
	logic [IW-1:0] idx_q;
	logic          valid_q;
	logic [6:0]    letter_q;
	logic          last_q;
	logic          load;
	logic          at_last;

	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			letters[k] = head_data[k*5 +: 5];
		end
	end

	assign len     = head_data[QW-1 -: LW];
	assign at_last = ((LW'(idx_q) + LW'(1)) == len);
	assign load    = !q_empty && (!valid_q || word_ready);
	assign pop     = load && at_last;

	assign word_valid = valid_q;
	assign letter     = letter_q;
	assign last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= at_last ? '0 : idx_q + IW'(1);
		end else if (word_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			letter_q <= LETTER_BASE + {2'b00, letters[idx_q]};
			last_q   <= at_last;
		end
	end

endmodule

[dv/markup_word_tokenizer_filter_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// markup_word_tokenizer_filter_core_tb
// Drives markup text through the tokenizer and checks every emitted letter
// against a cycle-free model of the word filter kept in the bench. Covers tag
// skipping, the apostrophe-s drop, case folding, length and consonant-run
// filtering, flush items, several register settings and output back-pressure.
// ----------------------------------------------------------------------------
module markup_word_tokenizer_filter_core_tb;
	import mwtf_pkg::*;

	localparam int BUF_DEPTH   = 14;
	localparam int IDLE_PCT    = 19;
	localparam int PHASE_ITEMS = 25;

	typedef struct packed {
		logic [6:0] letter;
		logic       last;
	} letter_out_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        byte_valid;
	logic        byte_ready;
	logic        operation;
	logic [7:0]  text_byte;
	logic        word_valid;
	logic        word_ready;
	logic [6:0]  letter;
	logic        last;

	// word filter model state
	cfg_t        cfg;
	logic        in_tag;
	logic        after_apos;
	logic [4:0]  word_buf [BUF_DEPTH];
	logic [3:0]  word_len;
	logic        has_vowel;
	logic [3:0]  cons_run;
	logic        run_bad;

	letter_out_t expected_letters [$];

	int errors;
	int items_sent;
	int parsed_items;
	int letters_seen;
	int words_seen;
	int settings_used;
	bit steady;
	int hold_request;
	int hold_left;

	markup_word_tokenizer_filter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.operation (operation),
		.text_byte (text_byte),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.letter    (letter),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("%0t: timeout, %0d letters still expected", $time, expected_letters.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic vowel_letter(logic [4:0] idx);
		case (idx)
			5'd0, 5'd4, 5'd8, 5'd14, 5'd20: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void clear_word();
		word_len  = '0;
		has_vowel = 1'b0;
		cons_run  = '0;
		run_bad   = 1'b0;
	endfunction

	function automatic void append_letter(logic [4:0] idx);
		if (word_len < BUF_DEPTH)
			word_buf[word_len] = idx;
		if (word_len <= BUF_DEPTH)
			word_len = word_len + 4'd1;
		if (vowel_letter(idx)) begin
			has_vowel = 1'b1;
			cons_run  = '0;
		end else begin
			if (cons_run < RUN_MAX)
				cons_run = cons_run + 4'd1;
			if (cons_run >= cfg.run_limit)
				run_bad = 1'b1;
		end
	endfunction

	function automatic void close_word();
		letter_out_t ent;
		if (word_len > 0 && word_len <= BUF_DEPTH && word_len >= cfg.min_len &&
				word_len <= cfg.max_len && has_vowel && !run_bad) begin
			for (int k = 0; k < word_len; k++) begin
				ent.letter = LETTER_BASE + 7'(word_buf[k]);
				ent.last   = (k == word_len - 1);
				expected_letters = {expected_letters, ent};
			end
		end
		clear_word();
	endfunction

	function automatic void tokenize_byte(op_t op, logic [7:0] c);
		if (op == OP_FLUSH) begin
			close_word();
			in_tag       = 1'b0;
			after_apos   = 1'b0;
			parsed_items = parsed_items + 1;
		end else if (c == CH_TAG_OPEN) begin
			in_tag = 1'b1;
		end else if (c == CH_TAG_CLOSE) begin
			in_tag = 1'b0;
		end else if (!in_tag) begin
			parsed_items = parsed_items + 1;
			if (after_apos && c == CH_LOWER_S) begin
				after_apos = 1'b0;
			end else begin
				after_apos = (c == CH_APOS);
				if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
					append_letter(5'(c - CH_UPPER_A));
				else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
					append_letter(5'(c - CH_LOWER_A));
				else
					close_word();
			end
		end
	endfunction

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			word_ready <= 1'b0;
		end else begin
			word_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin : check_letters
		letter_out_t head;
		if (arst_n && word_valid && word_ready) begin
			if (expected_letters.size() == 0) begin
				$display("%0t: unexpected letter, expected none, actual letter %h last %b",
					$time, letter, last);
				errors++;
			end else begin
				head = expected_letters.pop_front();
				if (letter !== head.letter) begin
					$display("%0t: letter mismatch, expected %h actual %h",
						$time, head.letter, letter);
					errors++;
				end
				if (last !== head.last) begin
					$display("%0t: last mismatch, expected %b actual %b",
						$time, head.last, last);
					errors++;
				end
				letters_seen++;
				if (head.last)
					words_seen++;
			end
		end
	end

	task automatic send_item(op_t op, logic [7:0] b);
		@(negedge clk);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				byte_valid <= 1'b0;
				@(negedge clk);
			end
		end
		byte_valid <= 1'b1;
		operation  <= op;
		text_byte  <= b;
		do @(posedge clk); while (!byte_ready);
		tokenize_byte(op, b);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(OP_BYTE, s[i]);
	endtask

	task automatic stop_bytes();
		@(negedge clk);
		byte_valid <= 1'b0;
	endtask

	task automatic drain_letters();
		int guard;
		guard = 0;
		while (expected_letters.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (expected_letters.size() != 0) begin
			$display("%0t: %0d expected letters never arrived, expected %h actual none",
				$time, expected_letters.size(), expected_letters[0].letter);
			errors++;
			expected_letters.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [3:0] val);
		logic [31:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {28'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MIN_LEN:   cfg.min_len   = val;
			REG_MAX_LEN:   cfg.max_len   = val;
			REG_RUN_LIMIT: cfg.run_limit = val;
			default: ;
		endcase
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== {28'd0, val}) begin
			$display("%0t: register %0d readback mismatch, expected %h actual %h",
				$time, idx, {28'd0, val}, rd);
			errors++;
		end
	endtask

	task automatic set_filter(logic [3:0] min_len, logic [3:0] max_len, logic [3:0] limit);
		write_reg(REG_MIN_LEN, min_len);
		write_reg(REG_MAX_LEN, max_len);
		write_reg(REG_RUN_LIMIT, limit);
		settings_used++;
	endtask

	task automatic end_phase();
		send_item(OP_FLUSH, 8'($urandom_range(255)));
		stop_bytes();
		drain_letters();
	endtask

	function automatic logic [7:0] pick_letter();
		string vowels;
		logic [7:0] ch;
		vowels = "aeiou";
		if ($urandom_range(99) < 35)
			ch = vowels[$urandom_range(4)];
		else
			ch = CH_LOWER_A + 8'($urandom_range(25));
		if ($urandom_range(99) < 30)
			ch = ch - 8'h20;
		return ch;
	endfunction

	task automatic send_tag();
		logic [7:0] inner;
		send_item(OP_BYTE, CH_TAG_OPEN);
		repeat ($urandom_range(0, 3)) begin
			inner = 8'($urandom_range(255));
			if (inner == CH_TAG_CLOSE)
				inner = CH_LOWER_A;
			send_item(OP_BYTE, inner);
		end
		send_item(OP_BYTE, CH_TAG_CLOSE);
	endtask

	task automatic send_word();
		int len;
		logic [7:0] sep;
		len = ($urandom_range(99) < 20) ? $urandom_range(11, 17) : $urandom_range(1, 8);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(99) < 4)
				send_tag();
			send_item(OP_BYTE, pick_letter());
		end
		if ($urandom_range(99) < 15) begin
			send_item(OP_BYTE, CH_APOS);
			send_item(OP_BYTE, ($urandom_range(99) < 70) ? CH_LOWER_S : pick_letter());
		end
		if ($urandom_range(99) < 10) begin
			send_item(OP_FLUSH, 8'($urandom_range(255)));
		end else begin
			sep = $urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 64));
			if (sep == CH_TAG_OPEN)
				sep = 8'h20;
			send_item(OP_BYTE, sep);
		end
	endtask

	task automatic send_unit();
		if ($urandom_range(99) < 15)
			send_item(($urandom_range(99) < 5) ? OP_FLUSH : OP_BYTE, 8'($urandom_range(255)));
		else
			send_word();
	endtask

	task automatic test_markup_rules();
		send_text("Rain's>Bo'Sail<p>ed");
		end_phase();
	endtask

	task automatic test_length_bounds();
		set_filter(4'd1, 4'd14, 4'd15);
		send_text("Extraordinaire");
		send_item(OP_BYTE, 8'hFF);
		send_text("Aeiouaeiouaeiou");
		end_phase();
	endtask

	task automatic test_backpressure();
		hold_request = 300;
		repeat (10) send_text("Mango ");
		end_phase();
	endtask

	task automatic test_random_text();
		logic [3:0] plan [7][3];
		int start;
		plan[0] = '{RST_MIN_LEN, RST_MAX_LEN, RST_RUN_LIMIT};
		plan[1] = '{4'd1, 4'd14, 4'd15};
		plan[2] = '{4'd14, 4'd14, 4'd15};
		plan[3] = '{4'd1, 4'd1, 4'd1};
		plan[4] = '{4'd9, 4'd3, 4'd4};
		for (int p = 5; p < 7; p++)
			plan[p] = '{4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)),
				4'($urandom_range(1, 15))};
		for (int p = 0; p < 7; p++) begin
			set_filter(plan[p][0], plan[p][1], plan[p][2]);
			steady = (p == 1);
			start  = parsed_items;
			while (parsed_items - start < PHASE_ITEMS)
				send_unit();
			end_phase();
			steady = 0;
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		byte_valid   = 1'b0;
		operation    = OP_BYTE;
		text_byte    = '0;
		word_ready   = 1'b0;
		errors       = 0;
		items_sent   = 0;
		parsed_items = 0;
		letters_seen = 0;
		words_seen   = 0;
		settings_used = 1;
		steady       = 0;
		hold_request = 0;
		hold_left    = 0;
		cfg          = '{min_len: RST_MIN_LEN, max_len: RST_MAX_LEN, run_limit: RST_RUN_LIMIT};
		in_tag       = 1'b0;
		after_apos   = 1'b0;
		clear_word();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_markup_rules();
		test_length_bounds();
		test_backpressure();
		test_random_text();

		stop_bytes();
		drain_letters();
		repeat (20) @(posedge clk);
		$display("Run sent %0d items (%0d outside tags) under %0d filter settings,",
			items_sent, parsed_items, settings_used);
		$display("and matched %0d letters forming %0d kept words.", letters_seen, words_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[files.f]
sv/mwtf_pkg.sv
sv/mwtf_front.sv
sv/mwtf_wordq.sv
sv/mwtf_back.sv
sv/markup_word_tokenizer_filter_core.sv
dv/markup_word_tokenizer_filter_core_tb.sv
